[src/hid_keyboard_report_to_key_events_unit_defines.svh]
// assertion macros for the keyboard report decoder
// used by the datapath, no other dependencies
`ifndef HID_KEYBOARD_REPORT_TO_KEY_EVENTS_UNIT_DEFINES_SVH
`define HID_KEYBOARD_REPORT_TO_KEY_EVENTS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define HKE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HKE_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define HKE_ASSERT(name, clk, rst, prop, msg)
`define HKE_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

[src/hke_pkg.sv]
// types, constants and decode functions for the keyboard report decoder
// no dependencies
package hke_pkg;

   localparam int NumSlots = 6;

   localparam logic [2:0] KindFrame = 3'd0;
   localparam logic [2:0] KindCaps  = 3'd1;
   localparam logic [2:0] KindMod   = 3'd2;
   localparam logic [2:0] KindRaw   = 3'd3;
   localparam logic [2:0] KindChar  = 3'd4;

   localparam logic [7:0] FrameStart = 8'hFE;
   localparam logic [7:0] FnCode     = 8'h9D;
   localparam logic [7:0] CapsCode   = 8'h39;
   localparam logic [7:0] RawLoA     = 8'h28;
   localparam logic [7:0] RawHiA     = 8'h2C;
   localparam logic [7:0] RawLoB     = 8'h3A;
   localparam logic [7:0] RawHiB     = 8'h65;
   localparam logic [7:0] LetterLo   = 8'h04;
   localparam logic [7:0] LetterHi   = 8'h1D;
   localparam logic [7:0] FnLetterHi = 8'h0F;
   localparam logic [7:0] DigitLo    = 8'h1E;
   localparam logic [7:0] DigitHi    = 8'h27;

   localparam logic [7:0] ShiftMask = 8'h22;
   localparam logic [7:0] AltMask   = 8'h44;
   localparam logic [7:0] CtrlMask  = 8'h11;

   localparam logic [3:0] FrameLast = 4'd8;
   localparam logic [3:0] ModLast   = 4'd2;
   localparam logic [3:0] SlotLast  = 4'(NumSlots - 1);

   typedef logic [NumSlots-1:0][7:0] slots_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_FRAME   = 3'd1,
      PH_CAPS    = 3'd2,
      PH_MOD     = 3'd3,
      PH_PRESS   = 3'd4,
      PH_RELEASE = 3'd5,
      PH_FLUSH   = 3'd6
   } phase_type;

   typedef struct packed {
      logic       load;
      phase_type  phase;
      logic [3:0] idx;
   } cmd_type;

   typedef struct packed {
      logic advance;
   } sts_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] value;
      logic       press;
   } event_type;

   function automatic logic slots_have(slots_type s, logic [7:0] code);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
         if (s[i] == code) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic slots_type fn_remap(slots_type s);
      slots_type r;
      logic      done;
      for (int i = 0; i < NumSlots; i++) begin
         if (s[i] >= LetterLo && s[i] <= FnLetterHi) begin
            r[i] = s[i] + 8'h36;
         end else if (s[i] >= DigitLo && s[i] <= DigitHi) begin
            r[i] = s[i] + 8'h1C;
         end else begin
            r[i] = s[i];
         end
      end
      done = 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
         if (!done && r[i] == FnCode) begin
            r[i] = 8'h00;
            done = 1'b1;
         end
      end
      return r;
   endfunction

   // digits and punctuation, plain and shifted
   function automatic logic [7:0] char_of(logic [7:0] code, logic shift);
      logic [7:0] ch;
      unique case (code)
         8'h1E:   ch = shift ? 8'h21 : 8'h31;
         8'h1F:   ch = shift ? 8'h40 : 8'h32;
         8'h20:   ch = shift ? 8'h23 : 8'h33;
         8'h21:   ch = shift ? 8'h24 : 8'h34;
         8'h22:   ch = shift ? 8'h25 : 8'h35;
         8'h23:   ch = shift ? 8'h5E : 8'h36;
         8'h24:   ch = shift ? 8'h26 : 8'h37;
         8'h25:   ch = shift ? 8'h2A : 8'h38;
         8'h26:   ch = shift ? 8'h28 : 8'h39;
         8'h27:   ch = shift ? 8'h29 : 8'h30;
         8'h2D:   ch = shift ? 8'h5F : 8'h2D;
         8'h2E:   ch = shift ? 8'h2B : 8'h3D;
         8'h2F:   ch = shift ? 8'h7B : 8'h5B;
         8'h30:   ch = shift ? 8'h7D : 8'h5D;
         8'h31:   ch = shift ? 8'h7C : 8'h5C;
         8'h32:   ch = shift ? 8'h7E : 8'h23;
         8'h33:   ch = shift ? 8'h3A : 8'h3B;
         8'h34:   ch = shift ? 8'h22 : 8'h27;
         8'h35:   ch = shift ? 8'h7E : 8'h60;
         8'h36:   ch = shift ? 8'h3C : 8'h2C;
         8'h37:   ch = shift ? 8'h3E : 8'h2E;
         8'h38:   ch = shift ? 8'h3F : 8'h2F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic event_type key_decode(logic [7:0] code, logic [7:0] mods,
                                            logic caps, logic press);
      event_type ev;
      logic      shift;
      logic      ctrl;
      shift    = |(mods & ShiftMask);
      ctrl     = |(mods & CtrlMask);
      ev.valid = 1'b0;
      ev.kind  = KindChar;
      ev.value = 8'h00;
      ev.press = press;
      if ((code >= RawLoA && code <= RawHiA) || (code >= RawLoB && code <= RawHiB)) begin
         ev.valid = 1'b1;
         ev.kind  = KindRaw;
         ev.value = code;
      end else if (code >= LetterLo && code <= LetterHi) begin
         ev.valid = 1'b1;
         if (ctrl) begin
            ev.value = code - 8'h03;
         end else if (shift ^ caps) begin
            ev.value = code + 8'h3D;
         end else begin
            ev.value = code + 8'h5D;
         end
      end else begin
         ev.value = char_of(code, shift);
         ev.valid = (ev.value != 8'h00);
      end
      return ev;
   endfunction

endpackage

[src/hid_keyboard_report_to_key_events_unit.sv]
// top level of the boot keyboard report decoder
// depends on hke_pkg, hke_controller and hke_datapath
//
// A keyboard report item produces a run of 9 to 25 result items: the 9-byte frame, an optional
// caps-lock toggle, shift/alt/ctrl changes, key presses and then key releases; the last item of
// the run carries last_of_run. A link-lost item produces nothing. After accepting a report the
// sequencer visits 25 candidate event slots one per cycle while the result side does not stall it,
// then a closing flush step, and it accepts no new item until the flush is done. It holds on a
// slot while the result side stalls and a waiting item must move to the output register. The final
// result of a run may still sit in the output register while the next item is accepted.
module hid_keyboard_report_to_key_events_unit
   import hke_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_modifier_bits,
   input  logic [7:0] req_reserved_byte,
   input  logic [7:0] req_key_slot_0,
   input  logic [7:0] req_key_slot_1,
   input  logic [7:0] req_key_slot_2,
   input  logic [7:0] req_key_slot_3,
   input  logic [7:0] req_key_slot_4,
   input  logic [7:0] req_key_slot_5,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_event_value,
   output logic       rsp_is_press,
   output logic       rsp_last_of_run
);

   cmd_type   cmd;
   sts_type   sts;
   slots_type req_slots;

   assign req_slots = {req_key_slot_5, req_key_slot_4, req_key_slot_3,
                       req_key_slot_2, req_key_slot_1, req_key_slot_0};

   hke_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .sts       (sts),
      .cmd       (cmd)
   );

   hke_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_modifier_bits (req_modifier_bits),
      .req_reserved_byte (req_reserved_byte),
      .req_slots         (req_slots),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_value   (rsp_event_value),
      .rsp_is_press      (rsp_is_press),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

[src/hke_controller.sv]
// step sequencer for the keyboard report decoder
// depends on hke_pkg
module hke_controller
   import hke_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_func,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_FRAME   = 7'b0000010,
      S_CAPS    = 7'b0000100,
      S_MOD     = 7'b0001000,
      S_PRESS   = 7'b0010000,
      S_RELEASE = 7'b0100000,
      S_FLUSH   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] idx_ff, idx_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd.load  = 1'b0;
      cmd.phase = PH_IDLE;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!req_func) begin
                  state_in = S_FRAME;
                  idx_in   = 4'd0;
               end
            end
         end
         S_FRAME: begin
            cmd.phase = PH_FRAME;
            if (sts.advance) begin
               if (idx_ff == FrameLast) begin
                  state_in = S_CAPS;
                  idx_in   = 4'd0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_CAPS: begin
            cmd.phase = PH_CAPS;
            if (sts.advance) begin
               state_in = S_MOD;
               idx_in   = 4'd0;
            end
         end
         S_MOD: begin
            cmd.phase = PH_MOD;
            if (sts.advance) begin
               if (idx_ff == ModLast) begin
                  state_in = S_PRESS;
                  idx_in   = 4'd0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_PRESS: begin
            cmd.phase = PH_PRESS;
            if (sts.advance) begin
               if (idx_ff == SlotLast) begin
                  state_in = S_RELEASE;
                  idx_in   = 4'd0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_RELEASE: begin
            cmd.phase = PH_RELEASE;
            if (sts.advance) begin
               if (idx_ff == SlotLast) begin
                  state_in = S_FLUSH;
                  idx_in   = 4'd0;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_FLUSH: begin
            cmd.phase = PH_FLUSH;
            if (sts.advance) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            idx_in   = 4'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

[src/hke_datapath.sv]
// report registers, event decode, pending item and output register
// depends on hke_pkg and the assertion macro header
`include "hid_keyboard_report_to_key_events_unit_defines.svh"

module hke_datapath
   import hke_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  logic       req_func,
   input  logic [7:0] req_modifier_bits,
   input  logic [7:0] req_reserved_byte,
   input  slots_type  req_slots,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_event_value,
   output logic       rsp_is_press,
   output logic       rsp_last_of_run
);

   logic [7:0] mods_ff, resv_ff, prev_mods_ff;
   slots_type  rep_slot_ff, fin_slot_ff, prev_slot_ff;
   logic       prev_valid_ff, caps_ff;
   event_type  pend_ff;
   logic       pend_valid_ff;
   logic       rsp_valid_ff, rsp_last_ff;
   logic [2:0] rsp_kind_ff;
   logic [7:0] rsp_value_ff;
   logic       rsp_press_ff;

   logic       fn_now, fn_was;
   slots_type  fin_in;
   logic [7:0] prior_mods;
   logic [2:0] slot_idx;
   logic [3:0] frame_sel;
   logic [7:0] press_code, release_code;
   logic       caps_cond;
   logic [7:0] mod_mask;
   event_type  cand;
   event_type  press_ev, release_ev;
   logic       flush, out_busy, stall, advance, push;

   assign fn_now     = slots_have(req_slots, FnCode);
   assign fn_was     = prev_valid_ff && slots_have(prev_slot_ff, FnCode);
   assign fin_in     = (fn_now && !fn_was) ? fn_remap(req_slots) : req_slots;
   assign prior_mods = prev_valid_ff ? prev_mods_ff : 8'h00;

   assign slot_idx     = cmd.idx[2:0];
   assign frame_sel    = cmd.idx - 4'd3;
   assign press_code   = fin_slot_ff[slot_idx];
   assign release_code = prev_slot_ff[slot_idx];
   assign caps_cond    = !slots_have(prev_slot_ff, CapsCode) && slots_have(fin_slot_ff, CapsCode);
   assign press_ev     = key_decode(press_code, mods_ff, caps_ff, 1'b1);
   assign release_ev   = key_decode(release_code, prior_mods, caps_ff, 1'b0);

   always_comb begin
      unique case (cmd.idx[1:0])
         2'd0:    mod_mask = ShiftMask;
         2'd1:    mod_mask = AltMask;
         default: mod_mask = CtrlMask;
      endcase
   end

   always_comb begin
      cand.valid = 1'b0;
      cand.kind  = KindFrame;
      cand.value = 8'h00;
      cand.press = 1'b0;
      unique case (cmd.phase)
         PH_FRAME: begin
            cand.valid = 1'b1;
            if (cmd.idx == 4'd0) begin
               cand.value = FrameStart;
            end else if (cmd.idx == 4'd1) begin
               cand.value = mods_ff;
            end else if (cmd.idx == 4'd2) begin
               cand.value = resv_ff;
            end else begin
               cand.value = fin_slot_ff[frame_sel[2:0]];
            end
         end
         PH_CAPS: begin
            cand.valid = caps_cond;
            cand.kind  = KindCaps;
            cand.value = {7'd0, ~caps_ff};
         end
         PH_MOD: begin
            cand.valid = |((mods_ff ^ prior_mods) & mod_mask);
            cand.kind  = KindMod;
            cand.value = {6'd0, cmd.idx[1:0]};
            cand.press = |(mods_ff & mod_mask);
         end
         PH_PRESS: begin
            cand       = press_ev;
            cand.valid = press_ev.valid && press_code != 8'h00 && press_code != CapsCode
                         && !(prev_valid_ff && slots_have(prev_slot_ff, press_code));
         end
         PH_RELEASE: begin
            cand       = release_ev;
            cand.valid = release_ev.valid && prev_valid_ff && release_code != 8'h00
                         && release_code != CapsCode && !slots_have(rep_slot_ff, release_code);
         end
         default: begin
            cand.valid = 1'b0;
         end
      endcase
   end

   assign flush    = (cmd.phase == PH_FLUSH);
   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign stall    = ((cand.valid && pend_valid_ff) || flush) && out_busy;
   assign advance  = (cmd.phase != PH_IDLE) && !stall;
   assign push     = advance && pend_valid_ff && (cand.valid || flush);
   assign sts.advance = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         caps_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_mods_ff  <= 8'h00;
         prev_slot_ff  <= '0;
      end else begin
         if (cmd.load && req_func) begin
            prev_valid_ff <= 1'b0;
         end
         if (advance && cmd.phase == PH_CAPS && caps_cond) begin
            caps_ff <= ~caps_ff;
         end
         if (advance && cand.valid) begin
            pend_valid_ff <= 1'b1;
         end else if (advance && flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (advance && flush) begin
            prev_valid_ff <= 1'b1;
            prev_mods_ff  <= mods_ff;
            prev_slot_ff  <= rep_slot_ff;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !req_func) begin
         mods_ff     <= req_modifier_bits;
         resv_ff     <= req_reserved_byte;
         rep_slot_ff <= req_slots;
         fin_slot_ff <= fin_in;
      end
      if (advance && cand.valid) begin
         pend_ff <= cand;
      end
      if (push) begin
         rsp_kind_ff  <= pend_ff.kind;
         rsp_value_ff <= pend_ff.value;
         rsp_press_ff <= pend_ff.press;
         rsp_last_ff  <= flush;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_value = rsp_value_ff;
   assign rsp_is_press    = rsp_press_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `HKE_ASSERT(a_flush_has_pending, clock, reset, flush |-> pend_valid_ff, "flush without pending item")
   `HKE_ASSERT(a_idle_no_pending, clock, reset, (cmd.phase == PH_IDLE) |-> !pend_valid_ff, "pending item left in idle")
   `HKE_ASSERT_NEVER(a_no_overwrite, clock, reset, push && rsp_valid_ff && !rsp_ready, "output item overwritten")
   `HKE_ASSERT(a_flush_ends_run, clock, reset, (flush && advance) |=> (rsp_valid_ff && rsp_last_ff && !pend_valid_ff), "run not closed by last item")

endmodule

[tb/tb_hid_keyboard_report_to_key_events_unit.sv]
`timescale 1ns / 1ps
// testbench for hid_keyboard_report_to_key_events_unit: a directed table and random typing
// sessions, every result checked against an event predictor in this file or a hand-written list
// depends on hke_pkg and the unit's rtl
module tb_hid_keyboard_report_to_key_events_unit;
   import hke_pkg::*;

   localparam logic       FuncReport   = 1'b0;
   localparam logic       FuncLinkLost = 1'b1;
   localparam logic [7:0] ModShift     = 8'd0;
   localparam logic [7:0] ModAlt       = 8'd1;
   localparam logic [7:0] ModCtrl      = 8'd2;
   localparam logic [7:0] EmptyCode    = 8'h00;
   localparam logic [7:0] PunctHi      = 8'h38;
   localparam logic [7:0] LowerA       = 8'h61;
   localparam logic [7:0] UpperA       = 8'h41;

   localparam int NumDirected = 24;
   localparam int NumRandom   = 480;
   localparam int IdlePercent = 13;
   localparam int QuietFrom   = 200;
   localparam int QuietTo     = 300;
   localparam int HoldAfter   = NumDirected + 120;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 40;
   localparam int CycleLimit  = 300000;
   localparam int PrintLimit  = 200;

   // characters for codes 0x1e..0x38
   localparam logic [0:26][7:0] PlainChars = {
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h0D, 8'h00, 8'h08, 8'h09, 8'h20,
      8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h23, 8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F
   };
   localparam logic [0:26][7:0] ShiftChars = {
      8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
      8'h0D, 8'h00, 8'h08, 8'h09, 8'h20,
      8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, 8'h7E, 8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F
   };

   typedef struct packed {
      logic             func;
      logic [7:0]       mods;
      logic [7:0]       reserved;
      logic [0:5][7:0]  slots;
   } report_item_type;

   typedef struct packed {
      report_item_type item;
      logic            typed;
   } row_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic       press;
      logic       last;
   } key_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_func = 1'b0;
   logic [7:0] req_modifier_bits = 8'h00;
   logic [7:0] req_reserved_byte = 8'h00;
   logic [7:0] req_key_slot_0 = 8'h00;
   logic [7:0] req_key_slot_1 = 8'h00;
   logic [7:0] req_key_slot_2 = 8'h00;
   logic [7:0] req_key_slot_3 = 8'h00;
   logic [7:0] req_key_slot_4 = 8'h00;
   logic [7:0] req_key_slot_5 = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_event_kind;
   logic [7:0] rsp_event_value;
   logic       rsp_is_press;
   logic       rsp_last_of_run;

   // predictor state
   logic [0:5][7:0] held_keys = '0;
   logic [7:0]      held_mods = 8'h00;
   logic            held_valid = 1'b0;
   logic            caps_on = 1'b0;

   // random typing session state
   logic [0:5][7:0] typing_keys = '0;
   logic [7:0]      typing_mods = 8'h00;

   row_type       directed_rows [0:NumDirected-1];
   key_event_type known_events [$];
   key_event_type run_events [$];
   key_event_type expected_events [$];
   int            mismatch_count = 0;
   int            accepted_reports = 0;
   int            cycle_count = 0;
   int            hold_left = 0;
   bit            hold_done = 1'b0;
   bit            quiet_stretch = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   hid_keyboard_report_to_key_events_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_modifier_bits (req_modifier_bits),
      .req_reserved_byte (req_reserved_byte),
      .req_key_slot_0    (req_key_slot_0),
      .req_key_slot_1    (req_key_slot_1),
      .req_key_slot_2    (req_key_slot_2),
      .req_key_slot_3    (req_key_slot_3),
      .req_key_slot_4    (req_key_slot_4),
      .req_key_slot_5    (req_key_slot_5),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_value   (rsp_event_value),
      .rsp_is_press      (rsp_is_press),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   function automatic logic slot_holds(logic [0:5][7:0] keys, logic [7:0] code);
      for (int i = 0; i < 6; i++) begin
         if (keys[i] == code) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void add_event(logic [2:0] kind, logic [7:0] value, logic press);
      run_events.push_back({kind, value, press, 1'b0});
   endfunction

   function automatic void add_key(logic [7:0] code, logic [7:0] mods, logic press);
      logic       shift;
      logic [7:0] ch;
      shift = |(mods & ShiftMask);
      ch = 8'h00;
      if ((code >= RawLoA && code <= RawHiA) || (code >= RawLoB && code <= RawHiB)) begin
         add_event(KindRaw, code, press);
         return;
      end
      if (code >= LetterLo && code <= LetterHi) begin
         if (|(mods & CtrlMask)) ch = code - LetterLo + 8'd1;
         else if (shift ^ caps_on) ch = UpperA + (code - LetterLo);
         else ch = LowerA + (code - LetterLo);
      end else if (code >= DigitLo && code <= PunctHi) begin
         ch = shift ? ShiftChars[code - DigitLo] : PlainChars[code - DigitLo];
      end
      if (ch != 8'h00) add_event(KindChar, ch, press);
   endfunction

   // fills run_events with the results of one report and advances the state
   function automatic void decode_report(report_item_type it);
      logic [0:5][7:0] shown;
      logic [7:0]      old_mods;
      logic [7:0]      changed;
      logic            cleared;
      key_event_type   ev;
      run_events.delete();
      if (it.func == FuncLinkLost) begin
         held_valid = 1'b0;
         return;
      end
      old_mods = held_valid ? held_mods : 8'h00;
      shown = it.slots;
      if (slot_holds(it.slots, FnCode) && !(held_valid && slot_holds(held_keys, FnCode))) begin
         for (int i = 0; i < 6; i++) begin
            if (it.slots[i] >= LetterLo && it.slots[i] <= FnLetterHi)
               shown[i] = RawLoB + (it.slots[i] - LetterLo);
            else if (it.slots[i] >= DigitLo && it.slots[i] <= DigitHi)
               shown[i] = RawLoB + (it.slots[i] - DigitLo);
         end
         cleared = 1'b0;
         for (int i = 0; i < 6; i++) begin
            if (!cleared && shown[i] == FnCode) begin
               shown[i] = EmptyCode;
               cleared = 1'b1;
            end
         end
      end
      add_event(KindFrame, FrameStart, 1'b0);
      add_event(KindFrame, it.mods, 1'b0);
      add_event(KindFrame, it.reserved, 1'b0);
      for (int i = 0; i < 6; i++) add_event(KindFrame, shown[i], 1'b0);
      if (!slot_holds(held_keys, CapsCode) && slot_holds(shown, CapsCode)) begin
         caps_on = !caps_on;
         add_event(KindCaps, {7'd0, caps_on}, 1'b0);
      end
      changed = it.mods ^ old_mods;
      if (|(changed & ShiftMask)) add_event(KindMod, ModShift, |(it.mods & ShiftMask));
      if (|(changed & AltMask)) add_event(KindMod, ModAlt, |(it.mods & AltMask));
      if (|(changed & CtrlMask)) add_event(KindMod, ModCtrl, |(it.mods & CtrlMask));
      for (int i = 0; i < 6; i++) begin
         if (shown[i] != EmptyCode && shown[i] != CapsCode &&
             !(held_valid && slot_holds(held_keys, shown[i])))
            add_key(shown[i], it.mods, 1'b1);
      end
      // releases look at the report as received, not the remapped one
      if (held_valid) begin
         for (int i = 0; i < 6; i++) begin
            if (held_keys[i] != EmptyCode && held_keys[i] != CapsCode &&
                !slot_holds(it.slots, held_keys[i]))
               add_key(held_keys[i], old_mods, 1'b0);
         end
      end
      held_keys = it.slots;
      held_mods = it.mods;
      held_valid = 1'b1;
      ev = run_events.pop_back();
      ev.last = 1'b1;
      run_events.push_back(ev);
   endfunction

   function automatic logic [7:0] pick_key_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 8'($urandom_range(LetterLo, LetterHi));
      if (r < 65) return 8'($urandom_range(DigitLo, PunctHi));
      if (r < 75) return 8'($urandom_range(RawLoB, RawHiB));
      if (r < 82) return FnCode;
      if (r < 88) return CapsCode;
      if (r < 93) return $urandom_range(0, 1) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(8'h66, 8'hFF));
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly a plausible typing session, with some link losses and garbage reports
   function automatic report_item_type next_typing_report();
      report_item_type it;
      int              r;
      r = $urandom_range(0, 99);
      it.func = FuncReport;
      it.mods = typing_mods;
      it.reserved = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
      it.slots = typing_keys;
      if (r < 3) begin
         it.func = FuncLinkLost;
         it.mods = 8'($urandom);
         it.reserved = 8'($urandom);
         it.slots = {16'($urandom), 32'($urandom)};
      end else if (r < 7) begin
         it.mods = 8'($urandom);
         it.reserved = 8'($urandom);
         it.slots = {16'($urandom), 32'($urandom)};
      end else if (r < 9) begin
         typing_keys = '0;
         typing_mods = 8'h00;
         it.mods = typing_mods;
         it.slots = typing_keys;
      end else begin
         for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 99) < 25)
               typing_keys[i] = ($urandom_range(0, 99) < 40) ? EmptyCode : pick_key_code();
         end
         r = $urandom_range(0, 99);
         if (r < 20) typing_mods = typing_mods ^ (8'd1 << $urandom_range(0, 7));
         else if (r < 25) typing_mods = 8'($urandom);
         it.mods = typing_mods;
         it.slots = typing_keys;
      end
      return it;
   endfunction

   task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
      if (mismatch_count < PrintLimit)
         $display("mismatch at %0t: %s got 'h%0h, expected 'h%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic drive_report(report_item_type it, logic typed);
      int            gap;
      key_event_type ev;
      if (!quiet_stretch && $urandom_range(0, 99) < IdlePercent) begin
         gap = $urandom_range(1, 30);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_modifier_bits <= it.mods;
      req_reserved_byte <= it.reserved;
      req_key_slot_0 <= it.slots[0];
      req_key_slot_1 <= it.slots[1];
      req_key_slot_2 <= it.slots[2];
      req_key_slot_3 <= it.slots[3];
      req_key_slot_4 <= it.slots[4];
      req_key_slot_5 <= it.slots[5];
      do @(posedge clock); while (!req_ready);
      accepted_reports++;
      decode_report(it);
      // rows with hand-written results take those instead of the predicted ones
      if (typed) begin
         run_events.delete();
         if (it.func == FuncReport) begin
            do begin
               ev = known_events.pop_front();
               run_events.push_back(ev);
            end while (!ev.last);
         end
      end
      foreach (run_events[i]) expected_events.push_back(run_events[i]);
   endtask

   task automatic check_event();
      key_event_type want;
      if (expected_events.size() == 0) begin
         note_mismatch("result with nothing expected, value", rsp_event_value, 8'h00);
         return;
      end
      want = expected_events.pop_front();
      if (rsp_event_kind !== want.kind)
         note_mismatch("event_kind", 8'(rsp_event_kind), 8'(want.kind));
      if (rsp_event_value !== want.value)
         note_mismatch("event_value", rsp_event_value, want.value);
      if (rsp_is_press !== want.press)
         note_mismatch("is_press", 8'(rsp_is_press), 8'(want.press));
      if (rsp_last_of_run !== want.last)
         note_mismatch("last_of_run", 8'(rsp_last_of_run), 8'(want.last));
   endtask

   // result side: random stalls, one long hold-off, a quiet stretch
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_event();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && accepted_reports >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_stretch || ($urandom_range(0, 99) >= IdlePercent);
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      directed_rows = '{
         {FuncReport,   8'h00, 8'h00, 48'h00_00_00_00_00_00, 1'b1},
         {FuncReport,   8'hFF, 8'hFF, 48'hFF_FF_FF_FF_FF_FF, 1'b1},
         {FuncReport,   8'h00, 8'h5A, 48'h00_00_00_00_00_00, 1'b0},
         {FuncLinkLost, 8'hA5, 8'h5A, 48'h9D_39_04_05_06_07, 1'b1},
         {FuncReport,   8'h00, 8'h00, 48'h04_05_06_07_08_1D, 1'b0},
         {FuncReport,   8'h02, 8'h00, 48'h04_05_06_07_08_1D, 1'b0},
         {FuncReport,   8'h20, 8'h00, 48'h1E_1F_2D_31_35_38, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h33_34_2E_2F_30_32, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h9D_04_0F_1E_27_10, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h9D_04_00_00_00_00, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h39_00_00_00_00_00, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h39_04_17_00_00_00, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h00_04_00_00_00_00, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h39_05_00_00_00_00, 1'b0},
         {FuncLinkLost, 8'h00, 8'h00, 48'h00_00_00_00_00_00, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h39_05_00_00_00_00, 1'b0},
         {FuncReport,   8'h11, 8'h00, 48'h04_1D_1E_00_00_00, 1'b0},
         {FuncReport,   8'h44, 8'h00, 48'h28_29_2C_3A_65_66, 1'b0},
         {FuncReport,   8'h88, 8'h00, 48'h01_02_03_39_9E_FF, 1'b0},
         {FuncReport,   8'h00, 8'hC3, 48'h04_04_04_1E_1E_00, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h9D_9D_05_20_27_0E, 1'b0},
         {FuncLinkLost, 8'h00, 8'h00, 48'h00_00_00_00_00_00, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h9D_06_00_00_00_00, 1'b0},
         {FuncReport,   8'h00, 8'h00, 48'h00_00_00_00_00_00, 1'b0}
      };
      known_events = '{
         {KindFrame, FrameStart, 1'b0, 1'b0},
         {KindFrame, 8'h00, 1'b0, 1'b0}, {KindFrame, 8'h00, 1'b0, 1'b0},
         {KindFrame, 8'h00, 1'b0, 1'b0}, {KindFrame, 8'h00, 1'b0, 1'b0},
         {KindFrame, 8'h00, 1'b0, 1'b0}, {KindFrame, 8'h00, 1'b0, 1'b0},
         {KindFrame, 8'h00, 1'b0, 1'b0}, {KindFrame, 8'h00, 1'b0, 1'b1},
         {KindFrame, FrameStart, 1'b0, 1'b0},
         {KindFrame, 8'hFF, 1'b0, 1'b0}, {KindFrame, 8'hFF, 1'b0, 1'b0},
         {KindFrame, 8'hFF, 1'b0, 1'b0}, {KindFrame, 8'hFF, 1'b0, 1'b0},
         {KindFrame, 8'hFF, 1'b0, 1'b0}, {KindFrame, 8'hFF, 1'b0, 1'b0},
         {KindFrame, 8'hFF, 1'b0, 1'b0}, {KindFrame, 8'hFF, 1'b0, 1'b0},
         {KindMod, ModShift, 1'b1, 1'b0},
         {KindMod, ModAlt, 1'b1, 1'b0},
         {KindMod, ModCtrl, 1'b1, 1'b1}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < NumDirected; n++) begin
         drive_report(directed_rows[n].item, directed_rows[n].typed);
      end
      for (int n = 0; n < NumRandom; n++) begin
         quiet_stretch = (n >= QuietFrom && n < QuietTo);
         drive_report(next_typing_report(), 1'b0);
      end
      quiet_stretch = 1'b0;
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
